/* rtl/hpli_pkg.sv */
`timescale 1ns / 1ps

package hpli_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int MAX_RESULTS = 3;
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int ACCEPT_LIMIT = QUEUE_DEPTH - MAX_RESULTS;
	localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] FMT_BYTE = 2'd0;
	localparam logic [1:0] FMT_RGB  = 2'd1;
	localparam logic [1:0] FMT_S16  = 2'd2;

	localparam logic [1:0] REG_SAMPLE_FORMAT  = 2'd0;
	localparam logic [1:0] REG_ORIGINAL_FIRST = 2'd1;

	typedef struct packed {
		logic [1:0]          fmt;
		logic                orig_first;
		logic [1:0]          pos;
		logic                last;
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [SAMPLE_W-1:0] c;
		logic [SAMPLE_W-1:0] d;
	} stage_t;

	typedef struct packed {
		logic [RES_CW-1:0]                    count;
		logic [MAX_RESULTS-1:0][SAMPLE_W-1:0] value;
		logic [MAX_RESULTS-1:0]               line_end;
	} res_t;

endpackage

/* rtl/half_pixel_line_interpolator.sv */
`timescale 1ns / 1ps

// Half-pixel line interpolator: shifts one line of samples by half a sample.
// Input channel (in_valid/in_ready): one sample per transaction, with
// last_in_line on the final sample of each line.
// Output channel (out_valid/out_ready): value and line_end; a line of n samples
// gives n results, the last carrying line_end.
// Configuration channel (cfg_valid/cfg_ready): cfg_index 0 sample_format,
// 1 original_first; always ready, write only between lines while idle.
// A sample's results pass the stage-one register and then the result queue.
// Throughput: one sample per cycle while in_ready is high; the final sample of
// a line yields up to three results, which leave an 8-entry result queue one
// per cycle while out_ready is high. in_ready is low while queue occupancy plus
// the results still being written would leave fewer than three free entries,
// so a stalled receiver holds the input after a few transactions and nothing
// is dropped. Reset clears the configuration to byte format with the last
// sample kept, empties the sample window and the queue, and starts a new line.
module half_pixel_line_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hpli_pkg::SAMPLE_W-1:0] sample,
	input  logic                          last_in_line,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hpli_pkg::SAMPLE_W-1:0] value,
	output logic                          line_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [1:0]                    cfg_data
);
	import hpli_pkg::*;

	logic                valid_s1;
	stage_t              stage_s1;
	res_t                res;
	logic                room;
	logic [QUEUE_CW-1:0] q_count;
	logic                in_accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = room;
	assign in_accept = in_valid && in_ready;

	hpli_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.sample       (sample),
		.last_in_line (last_in_line),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.valid_s1     (valid_s1),
		.stage_s1     (stage_s1)
	);

	hpli_filter u_filter (
		.valid (valid_s1),
		.stage (stage_s1),
		.res   (res)
	);

	hpli_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.pop       (out_valid && out_ready),
		.room      (room),
		.count     (q_count),
		.out_valid (out_valid),
		.value     (value),
		.line_end  (line_end)
	);

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_line_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && stage_s1.last |-> res.count != '0)
		else $error("end of line produced no result");

	a_no_spurious_push: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> res.count == '0)
		else $error("results pushed without a transaction");

	a_accept_to_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted sample missing from stage one");
`endif

endmodule

/* rtl/hpli_front.sv */
`timescale 1ns / 1ps

module hpli_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [hpli_pkg::SAMPLE_W-1:0] sample,
	input  logic                          last_in_line,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [1:0]                    cfg_data,
	output logic                          valid_s1,
	output hpli_pkg::stage_t              stage_s1
);
	import hpli_pkg::*;

	logic [1:0]          fmt_q;
	logic                orig_first_q;
	logic [1:0]          pos_q;
	logic [SAMPLE_W-1:0] win0_q;
	logic [SAMPLE_W-1:0] win1_q;
	logic [SAMPLE_W-1:0] win2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q        <= FMT_BYTE;
			orig_first_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_SAMPLE_FORMAT) begin
				fmt_q <= cfg_data;
			end else if (cfg_index == REG_ORIGINAL_FIRST) begin
				orig_first_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 2'd0;
			win0_q   <= '0;
			win1_q   <= '0;
			win2_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last_in_line) begin
					pos_q  <= 2'd0;
					win0_q <= '0;
					win1_q <= '0;
					win2_q <= '0;
				end else begin
					win2_q <= win1_q;
					win1_q <= win0_q;
					win0_q <= sample;
					if (pos_q != 2'd3) begin
						pos_q <= pos_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.fmt        <= fmt_q;
			stage_s1.orig_first <= orig_first_q;
			stage_s1.pos        <= pos_q;
			stage_s1.last       <= last_in_line;
			stage_s1.a          <= win2_q;
			stage_s1.b          <= win1_q;
			stage_s1.c          <= win0_q;
			stage_s1.d          <= sample;
		end
	end

endmodule

/* rtl/hpli_filter.sv */
`timescale 1ns / 1ps

module hpli_filter (
	input  logic             valid,
	input  hpli_pkg::stage_t stage,
	output hpli_pkg::res_t   res
);
	import hpli_pkg::*;

	function automatic logic [7:0] filt8(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		logic [8:0]  sum_bc;
		logic [8:0]  sum_ad;
		logic [12:0] t;
		logic [12:0] sh;
		sum_bc = {1'b0, b} + {1'b0, c};
		sum_ad = {1'b0, a} + {1'b0, d};
		t      = ({4'b0, sum_bc} * 13'd5) - {4'b0, sum_ad};
		sh     = {{3{t[12]}}, t[12:3]};
		if (sh[12]) begin
			filt8 = 8'd0;
		end else if (|sh[11:8]) begin
			filt8 = 8'd255;
		end else begin
			filt8 = sh[7:0];
		end
	endfunction

	function automatic logic [7:0] avg8(input logic [7:0] b, input logic [7:0] c);
		logic [8:0] sum_bc;
		sum_bc = {1'b0, b} + {1'b0, c};
		avg8   = sum_bc[8:1];
	endfunction

	function automatic logic [15:0] filt16(input logic [15:0] a, input logic [15:0] b,
		input logic [15:0] c, input logic [15:0] d);
		logic [16:0] sum_bc;
		logic [16:0] sum_ad;
		logic [20:0] t;
		sum_bc = {b[15], b} + {c[15], c};
		sum_ad = {a[15], a} + {d[15], d};
		t      = ({{4{sum_bc[16]}}, sum_bc} * 21'd5) - {{4{sum_ad[16]}}, sum_ad};
		filt16 = t[18:3];
	endfunction

	function automatic logic [15:0] avg16(input logic [15:0] b, input logic [15:0] c);
		logic [16:0] sum_bc;
		sum_bc = {b[15], b} + {c[15], c};
		avg16  = sum_bc[16:1];
	endfunction

	logic [SAMPLE_W-1:0] filt_val;
	logic [SAMPLE_W-1:0] avg_val;
	logic [SAMPLE_W-1:0] keep_val;
	logic [RES_CW-1:0]   idx;

	always_comb begin
		filt_val = '0;
		avg_val  = '0;
		keep_val = '0;
		unique case (stage.fmt)
			FMT_RGB: begin
				for (int ch = 0; ch < 3; ch++) begin
					filt_val[ch*8 +: 8] = filt8(stage.a[ch*8 +: 8], stage.b[ch*8 +: 8],
						stage.c[ch*8 +: 8], stage.d[ch*8 +: 8]);
					avg_val[ch*8 +: 8]  = avg8(stage.c[ch*8 +: 8], stage.d[ch*8 +: 8]);
				end
				keep_val = stage.d;
			end
			FMT_S16: begin
				filt_val[15:0] = filt16(stage.a[15:0], stage.b[15:0], stage.c[15:0],
					stage.d[15:0]);
				avg_val[15:0]  = avg16(stage.c[15:0], stage.d[15:0]);
				keep_val[15:0] = stage.d[15:0];
			end
			default: begin
				filt_val[7:0] = filt8(stage.a[7:0], stage.b[7:0], stage.c[7:0], stage.d[7:0]);
				avg_val[7:0]  = avg8(stage.c[7:0], stage.d[7:0]);
				keep_val[7:0] = stage.d[7:0];
			end
		endcase
	end

	// results packed in emission order
	always_comb begin
		res = '0;
		idx = '0;
		if (valid) begin
			if (stage.pos == 2'd0) begin
				if (stage.last || stage.orig_first) begin
					res.value[idx]    = keep_val;
					res.line_end[idx] = stage.last;
					idx = idx + 1'b1;
				end
			end else begin
				if (stage.pos == 2'd3) begin
					res.value[idx]    = filt_val;
					res.line_end[idx] = 1'b0;
					idx = idx + 1'b1;
				end
				if (stage.pos == 2'd1 || stage.last) begin
					res.value[idx]    = avg_val;
					res.line_end[idx] = stage.last && stage.orig_first;
					idx = idx + 1'b1;
				end
				if (stage.last && !stage.orig_first) begin
					res.value[idx]    = keep_val;
					res.line_end[idx] = 1'b1;
					idx = idx + 1'b1;
				end
			end
		end
		res.count = idx;
	end

endmodule

/* rtl/hpli_queue.sv */
`timescale 1ns / 1ps

module hpli_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hpli_pkg::res_t                push,
	input  logic                          pop,
	output logic                          room,
	output logic [hpli_pkg::QUEUE_CW-1:0] count,
	output logic                          out_valid,
	output logic [hpli_pkg::SAMPLE_W-1:0] value,
	output logic                          line_end
);
	import hpli_pkg::*;

	logic [SAMPLE_W:0]   mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic [QUEUE_CW-1:0] push_n;

	assign push_n = QUEUE_CW'(push.count);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (RES_CW'(i) < push.count) begin
				mem[wr_ptr_q + QUEUE_AW'(i)] <= {push.value[i], push.line_end[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + push_n - QUEUE_CW'(pop);
		end
	end

	// a new transaction may need MAX_RESULTS slots once this push has landed
	assign room      = (count_q + push_n) <= QUEUE_CW'(ACCEPT_LIMIT);
	assign count     = count_q;
	assign out_valid = (count_q != '0);
	assign value     = mem[rd_ptr_q][SAMPLE_W:1];
	assign line_end  = mem[rd_ptr_q][0];

endmodule
